// File: rtl/srsp_pkg.sv
package srsp_pkg;

  localparam int VW = 33;   // vector component, signed
  localparam int UW = 28;   // unit vector component, signed
  localparam int KW = 38;   // projection along the ray, signed
  localparam int CFG_AW = 3;

  localparam logic [CFG_AW-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RADIUS   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_EPS      = 3'd4;

  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [30:0] EPS_RESET    = 31'd66;

  typedef enum logic [1:0] {
    KIND_RAY    = 2'd0,
    KIND_SEG    = 2'd1,
    KIND_POINT  = 2'd2,
    KIND_SPHERE = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        other_radius;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] near_t;
    logic signed [31:0] far_t;
  } out_t;

  // queue entry: classified request
  typedef struct packed {
    kind_t              kind;
    logic [2:0][VW-1:0] oc;
    logic [2:0]         dneg;
    logic [2:0][VW-1:0] dmag;
    logic               sh;
    logic [31:0]        lim;
  } fr_t;

  // state carried down the back pipeline
  typedef struct packed {
    kind_t              kind;
    logic [2:0][VW-1:0] oc;
    logic [2:0]         dneg;
    logic [2:0][VW-1:0] dmag;
    logic               sh;
    logic [VW-1:0]      len;
    logic [2:0][UW-1:0] u;
    logic [KW-1:0]      k;
    logic               simple_hit;
    logic               over;
    logic               miss;
    logic               tangent;
  } bk_t;

  function automatic logic [VW-1:0] mag_v(input logic [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : v;
  endfunction

endpackage

// File: rtl/srsp_front.sv
module srsp_front (
  input  srsp_pkg::in_t       req,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         radius,
  output srsp_pkg::fr_t       ent
);
  import srsp_pkg::*;

  logic signed [VW-1:0] a [3];
  logic signed [VW-1:0] b [3];
  logic signed [VW-1:0] c [3];
  logic signed [VW-1:0] oc [3];
  logic signed [VW-1:0] dv [3];
  kind_t                kind;
  logic                 big;

  always_comb begin
    kind = kind_t'(req.kind);
    a[0] = VW'(req.first_x);
    a[1] = VW'(req.first_y);
    a[2] = VW'(req.first_z);
    b[0] = VW'(req.second_x);
    b[1] = VW'(req.second_y);
    b[2] = VW'(req.second_z);
    c[0] = VW'(center_x);
    c[1] = VW'(center_y);
    c[2] = VW'(center_z);
    big  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      oc[i] = a[i] - c[i];
      unique case (kind)
        KIND_RAY:    dv[i] = b[i];
        KIND_SEG:    dv[i] = b[i] - a[i];
        KIND_POINT:  dv[i] = oc[i];
        KIND_SPHERE: dv[i] = b[i] - c[i];
        default:     dv[i] = b[i];
      endcase
      ent.oc[i]   = oc[i];
      ent.dneg[i] = dv[i][VW-1];
      ent.dmag[i] = mag_v(dv[i]);
      if (ent.dmag[i] > {2'b01, 31'd0}) big = 1'b1;
    end
    ent.kind = kind;
    // halve the components when one would overflow its square (not for sphere requests)
    ent.sh   = big && (kind != KIND_SPHERE);
    ent.lim  = (kind == KIND_SPHERE) ? ({1'b0, radius} + {1'b0, req.other_radius})
                                     : {1'b0, radius};
  end

endmodule

// File: rtl/srsp_queue.sv
module srsp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srsp_pkg::fr_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output srsp_pkg::fr_t rdata
);
  import srsp_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  fr_t           ent [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) ent[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// File: rtl/srsp_isqrt.sv
module srsp_isqrt #(
  parameter int  ITERS = 32,
  parameter type side_t = logic
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] x,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] res,
  output side_t       out_side
);

  localparam int L = (ITERS < 32) ? ITERS : 32;

  logic        vld [0:L];
  logic [63:0] xs  [0:L];
  logic [31:0] rs  [0:L];
  logic [63:0] sqs [0:L];
  side_t       sd  [0:L];

  assign vld[0] = in_valid;
  assign xs[0]  = x;
  assign rs[0]  = '0;
  assign sqs[0] = '0;
  assign sd[0]  = in_side;

  // one result bit per stage, square of the partial root kept alongside
  for (genvar g = 0; g < L; g++) begin : g_stage
    localparam int B = 31 - g;
    logic [65:0] cand;
    logic        take;

    assign cand = {2'b0, sqs[g]} + ({34'd0, rs[g]} << (B + 1)) + (66'd1 << (2 * B));
    assign take = cand <= {2'b0, xs[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[g+1]  <= xs[g];
        sd[g+1]  <= sd[g];
        rs[g+1]  <= take ? (rs[g] | (32'd1 << B)) : rs[g];
        sqs[g+1] <= take ? cand[63:0] : sqs[g];
      end
    end
  end

  assign out_valid = vld[L];
  assign res       = rs[L];
  assign out_side  = sd[L];

endmodule

// File: rtl/srsp_back.sv
module srsp_back #(
  parameter int FRAC_BITS  = 16,
  parameter int SQRT_ITERS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  srsp_pkg::fr_t in_ent,
  output logic          in_ready,
  input  logic [30:0]   radius,
  input  logic [30:0]   tangent_eps,
  output logic          out_valid,
  input  logic          out_ready,
  output srsp_pkg::out_t out_data
);
  import srsp_pkg::*;

  localparam int QW = FRAC_BITS + 3;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [61:0] r2;
  logic [63:0] eps_sh;
  always_ff @(posedge clk) begin
    r2 <= {31'd0, radius} * {31'd0, radius};
  end
  assign eps_sh = 64'(tangent_eps) << FRAC_BITS;

  // stage 1: squares of the vector and of the limit radius
  bk_t                 b0;
  logic                s1_v;
  bk_t                 s1_b;
  logic [2:0][65:0]    s1_sq;
  logic [63:0]         s1_lim2;
  logic [2:0][VW-1:0]  m0;

  always_comb begin
    b0      = '0;
    b0.kind = in_ent.kind;
    b0.oc   = in_ent.oc;
    b0.dneg = in_ent.dneg;
    b0.dmag = in_ent.dmag;
    b0.sh   = in_ent.sh;
    for (int i = 0; i < 3; i++) m0[i] = in_ent.dmag[i] >> in_ent.sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_b    <= b0;
      s1_lim2 <= 64'(in_ent.lim) * 64'(in_ent.lim);
      for (int i = 0; i < 3; i++) s1_sq[i] <= 66'(m0[i]) * 66'(m0[i]);
    end
  end

  // stage 2: sum and containment compare
  logic        s2_v;
  bk_t         s2_b;
  logic [63:0] s2_x;
  logic [66:0] sum1;
  bk_t         b1;

  always_comb begin
    sum1          = 67'(s1_sq[0]) + 67'(s1_sq[1]) + 67'(s1_sq[2]);
    b1            = s1_b;
    // a halved point lies beyond the radius on at least one axis
    b1.simple_hit = !s1_b.sh && (sum1 <= 67'(s1_lim2));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_b <= b1;
      s2_x <= sum1[63:0];
    end
  end

  // length of the direction vector
  logic        a_v;
  logic [31:0] a_res;
  bk_t         a_b;

  srsp_isqrt #(.ITERS(SQRT_ITERS), .side_t(bk_t)) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_v),
    .x         (s2_x),
    .in_side   (s2_b),
    .out_valid (a_v),
    .res       (a_res),
    .out_side  (a_b)
  );

  // restoring divider, three lanes, one quotient bit per stage
  logic             dv_v   [0:QW];
  bk_t              dv_b   [0:QW];
  logic [2:0][33:0] dv_rem [0:QW];
  logic [2:0][QW-1:0] dv_q [0:QW];

  always_comb begin
    dv_v[0]     = a_v;
    dv_b[0]     = a_b;
    dv_b[0].len = a_b.sh ? {a_res, 1'b0} : {1'b0, a_res};
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = 34'(a_b.dmag[i] >> 3);
      dv_q[0][i]   = '0;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int   QB  = QW - 1 - g;
    localparam int   NB  = (QB >= FRAC_BITS) ? QB - FRAC_BITS : 0;
    localparam logic HAS = (QB >= FRAC_BITS);
    logic [2:0][34:0]   t;
    logic [2:0][33:0]   rn;
    logic [2:0][QW-1:0] qn;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {dv_rem[g][i], HAS & dv_b[g].dmag[i][NB]};
        if (t[i] >= {2'b0, dv_b[g].len}) begin
          rn[i] = 34'(t[i] - {2'b0, dv_b[g].len});
          qn[i] = dv_q[g][i] | (QW'(1) << QB);
        end else begin
          rn[i] = t[i][33:0];
          qn[i] = dv_q[g][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g+1] <= 1'b0;
      end else if (en) begin
        dv_v[g+1] <= dv_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_b[g+1]   <= dv_b[g];
        dv_rem[g+1] <= rn;
        dv_q[g+1]   <= qn;
      end
    end
  end

  // stage 4: signed unit vector
  logic s4_v;
  bk_t  s4_b;
  bk_t  b4;

  always_comb begin
    b4 = dv_b[QW];
    for (int i = 0; i < 3; i++) begin
      b4.u[i] = dv_b[QW].dneg[i] ? UW'(-UW'(dv_q[QW][i])) : UW'(dv_q[QW][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) s4_b <= b4;
  end

  // stage 5: products for the projection
  logic                     s5_v;
  bk_t                      s5_b;
  logic signed [VW+UW-1:0]  s5_prod [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_b <= s4_b;
      for (int i = 0; i < 3; i++) begin
        s5_prod[i] <= (VW+UW)'($signed(s4_b.oc[i])) * (VW+UW)'($signed(s4_b.u[i]));
      end
    end
  end

  // stage 6: projection k, truncated toward zero
  localparam int DW = VW + UW + 2;
  logic              s6_v;
  bk_t               s6_b;
  logic signed [DW-1:0] dot;
  logic [DW-1:0]     dot_m;
  logic [DW-1:0]     k_m;
  bk_t               b6;

  always_comb begin
    dot   = DW'(s5_prod[0]) + DW'(s5_prod[1]) + DW'(s5_prod[2]);
    dot_m = dot[DW-1] ? DW'(-dot) : DW'(dot);
    k_m   = dot_m >> FRAC_BITS;
    b6    = s5_b;
    b6.k  = dot[DW-1] ? KW'(-k_m) : KW'(k_m);
  end

  always_ff @(posedge clk) begin
    if (en) s6_b <= b6;
  end

  // stage 7: k times each unit component
  localparam int PW = KW + UW;
  logic                 s7_v;
  bk_t                  s7_b;
  logic signed [PW-1:0] s7_ku [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b <= s6_b;
      for (int i = 0; i < 3; i++) begin
        s7_ku[i] <= PW'($signed(s6_b.k)) * PW'($signed(s6_b.u[i]));
      end
    end
  end

  // stage 8: perpendicular offset and per-axis reject
  logic             s8_v;
  bk_t              s8_b;
  logic [2:0][30:0] s8_pm;
  logic [PW-1:0]    ku_m  [3];
  logic [PW-1:0]    ku_t  [3];
  logic signed [PW:0] p   [3];
  logic [PW:0]      p_m   [3];
  bk_t              b8;

  always_comb begin
    b8      = s7_b;
    b8.over = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ku_m[i] = s7_ku[i][PW-1] ? PW'(-s7_ku[i]) : PW'(s7_ku[i]);
      ku_t[i] = ku_m[i] >> FRAC_BITS;
      p[i]    = s7_ku[i][PW-1] ? ((PW+1)'($signed(s7_b.oc[i])) + (PW+1)'(ku_t[i]))
                               : ((PW+1)'($signed(s7_b.oc[i])) - (PW+1)'(ku_t[i]));
      p_m[i]  = p[i][PW] ? (PW+1)'(-p[i]) : (PW+1)'(p[i]);
      if (p_m[i] > (PW+1)'(radius)) b8.over = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_b <= b8;
      for (int i = 0; i < 3; i++) s8_pm[i] <= p_m[i][30:0];
    end
  end

  // stage 9: squares of the offset
  logic             s9_v;
  bk_t              s9_b;
  logic [2:0][61:0] s9_pp;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_b <= s8_b;
      for (int i = 0; i < 3; i++) s9_pp[i] <= 62'(s8_pm[i]) * 62'(s8_pm[i]);
    end
  end

  // stage 10: chord half length squared, miss and tangent flags
  logic        s10_v;
  bk_t         s10_b;
  logic [63:0] s10_x;
  logic [63:0] perp2;
  logic [63:0] kk;
  bk_t         b10;

  always_comb begin
    perp2      = 64'(s9_pp[0]) + 64'(s9_pp[1]) + 64'(s9_pp[2]);
    kk         = 64'(r2) - perp2;
    b10        = s9_b;
    b10.miss   = s9_b.over || (perp2 > 64'(r2)) || (s9_b.len == '0);
    b10.tangent = kk < eps_sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_b <= b10;
      s10_x <= kk;
    end
  end

  logic        c_v;
  logic [31:0] c_res;
  bk_t         c_b;

  srsp_isqrt #(.ITERS(SQRT_ITERS), .side_t(bk_t)) u_chord_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s10_v),
    .x         (s10_x),
    .in_side   (s10_b),
    .out_valid (c_v),
    .res       (c_res),
    .out_side  (c_b)
  );

  // result assembly and saturation
  localparam int NW = KW + 2;
  logic signed [NW-1:0] nk;
  logic signed [NW-1:0] sv;
  logic signed [NW-1:0] lv;
  logic signed [NW-1:0] nr;
  logic signed [NW-1:0] fr;
  logic                 hit;
  out_t                 res_n;

  function automatic logic signed [31:0] sat32(input logic signed [NW-1:0] x);
    if (x > NW'(32'sh7fffffff)) return 32'sh7fffffff;
    if (x < -NW'(33'sh080000000)) return 32'sh80000000;
    return x[31:0];
  endfunction

  always_comb begin
    nk  = -NW'($signed(c_b.k));
    sv  = NW'({1'b0, c_res});
    lv  = NW'({1'b0, c_b.len});
    hit = 1'b0;
    nr  = '0;
    fr  = '0;
    unique case (c_b.kind)
      KIND_RAY, KIND_SEG: begin
        hit = !c_b.miss;
        if (c_b.tangent) begin
          nr = nk;
          fr = '0;
        end else begin
          nr = nk - sv;
          fr = nk + sv;
        end
        if (c_b.kind == KIND_SEG && hit) begin
          priority if (nr < 0 || fr < 0) begin
            nr = '0;
            fr = '0;
          end else if (!(nr <= lv || fr <= lv)) begin
            hit = 1'b0;
          end
        end
      end
      KIND_POINT: begin
        hit = c_b.simple_hit;
        nr  = lv - NW'({1'b0, radius});
        fr  = '0;
      end
      KIND_SPHERE: begin
        hit = c_b.simple_hit;
      end
      default: hit = 1'b0;
    endcase
    // drop distances on a miss, except for the signed point distance
    if (!hit && c_b.kind != KIND_POINT) begin
      nr = '0;
      fr = '0;
    end
    res_n.hit    = hit;
    res_n.near_t = sat32(nr);
    res_n.far_t  = sat32(fr);
  end

  always_ff @(posedge clk) begin
    if (en) out_data <= res_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s4_v      <= 1'b0;
      s5_v      <= 1'b0;
      s6_v      <= 1'b0;
      s7_v      <= 1'b0;
      s8_v      <= 1'b0;
      s9_v      <= 1'b0;
      s10_v     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s4_v      <= dv_v[QW];
      s5_v      <= s4_v;
      s6_v      <= s5_v;
      s7_v      <= s6_v;
      s8_v      <= s7_v;
      s9_v      <= s8_v;
      s10_v     <= s9_v;
      out_valid <= c_v;
    end
  end

endmodule

// File: rtl/sphere_ray_segment_point_tests_unit.sv
// Sphere query unit: tests ray, segment, point and sphere requests against
// one sphere held in configuration (center, radius, tangent threshold).
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); write
// it only while no request is in flight. Requests enter on in_valid/in_ready,
// each giving exactly one result on out_valid/out_ready, in order.
// Throughput: one request per cycle while out_ready keeps the pipeline moving. The
// path runs through two pipelined square roots and a pipelined divider.
// A four-entry queue sits between the front classifier and the arithmetic
// pipeline. When out_ready is low the pipeline holds, the queue fills, and
// in_ready drops once it is full; requests are never lost.
// Reset (rst, synchronous) empties the queue and pipeline and loads the
// register defaults: center 0, radius 1.0, tangent threshold 66.
module sphere_ray_segment_point_tests_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int SQRT_ITERS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srsp_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  srsp_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output srsp_pkg::out_t                  out_data
);
  import srsp_pkg::*;

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic [30:0]        radius;
  logic [30:0]        tangent_eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      radius      <= RADIUS_RESET;
      tangent_eps <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_X: center_x    <= cfg_wdata;
        REG_CENTER_Y: center_y    <= cfg_wdata;
        REG_CENTER_Z: center_z    <= cfg_wdata;
        REG_RADIUS:   radius      <= cfg_wdata[30:0];
        REG_EPS:      tangent_eps <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  fr_t  ent;
  fr_t  q_ent;
  logic q_full;
  logic q_nonempty;
  logic back_ready;

  srsp_front u_front (
    .req      (in_data),
    .center_x (center_x),
    .center_y (center_y),
    .center_z (center_z),
    .radius   (radius),
    .ent      (ent)
  );

  assign in_ready = !q_full;

  srsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid),
    .wdata    (ent),
    .full     (q_full),
    .pop      (back_ready),
    .nonempty (q_nonempty),
    .rdata    (q_ent)
  );

  srsp_back #(.FRAC_BITS(FRAC_BITS), .SQRT_ITERS(SQRT_ITERS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_nonempty),
    .in_ent      (q_ent),
    .in_ready    (back_ready),
    .radius      (radius),
    .tangent_eps (tangent_eps),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
